// File: rtl/core/ohlcv_pkg.sv
// Shared constants, codes and types for the OHLCV bar aggregator.
`timescale 1ns / 1ps
`default_nettype none

package ohlcv_pkg;

  localparam int unsigned PriceW  = 31;  // price width, 1/10000 units
  localparam int unsigned VolInW  = 24;  // per fine bar volume / trade count
  localparam int unsigned SumW    = 32;  // saturating volume / trade sums
  localparam int unsigned WsW     = 64;  // weighted price sum
  localparam int unsigned MinW    = 11;  // minute of day
  localparam int unsigned EndW    = 12;  // window end, may pass one day
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CntW    = $clog2(VolInW);

  localparam logic [CfgIdxW-1:0] CfgSessStart = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSessEnd   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBarMin    = 2'd2;

  localparam logic KindBar   = 1'b0;
  localparam logic KindFlush = 1'b1;

  localparam logic [MinW-1:0] SessStartRst = 11'd570;
  localparam logic [MinW-1:0] SessEndRst   = 11'd960;
  localparam logic [MinW-1:0] BarMinRst    = 11'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REM,
    ST_CLOSE,
    ST_MUL,
    ST_ACC
  } agg_state_e;

endpackage

`default_nettype wire

// File: rtl/core/ohlcv_ifs.sv
// Handshake interfaces: fine bar input, combined bar output, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface ohlcv_bar_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [ohlcv_pkg::MinW-1:0]   bar_time_min;
  logic [ohlcv_pkg::PriceW-1:0] open_price;
  logic [ohlcv_pkg::PriceW-1:0] high_price;
  logic [ohlcv_pkg::PriceW-1:0] low_price;
  logic [ohlcv_pkg::PriceW-1:0] close_price;
  logic [ohlcv_pkg::PriceW-1:0] avg_price;
  logic [ohlcv_pkg::VolInW-1:0] bar_volume;
  logic [ohlcv_pkg::VolInW-1:0] trade_count;

  modport source (
    output valid, kind, bar_time_min, open_price, high_price, low_price,
           close_price, avg_price, bar_volume, trade_count,
    input  ready
  );
  modport sink (
    input  valid, kind, bar_time_min, open_price, high_price, low_price,
           close_price, avg_price, bar_volume, trade_count,
    output ready
  );
endinterface

interface ohlcv_bar_out_if;
  logic                         valid;
  logic                         ready;
  logic [ohlcv_pkg::MinW-1:0]   window_start_min;
  logic [ohlcv_pkg::PriceW-1:0] out_open;
  logic [ohlcv_pkg::PriceW-1:0] out_high;
  logic [ohlcv_pkg::PriceW-1:0] out_low;
  logic [ohlcv_pkg::PriceW-1:0] out_close;
  logic [ohlcv_pkg::PriceW-1:0] out_vwap;
  logic [ohlcv_pkg::SumW-1:0]   out_volume;
  logic [ohlcv_pkg::SumW-1:0]   out_trades;

  modport source (
    output valid, window_start_min, out_open, out_high, out_low, out_close,
           out_vwap, out_volume, out_trades,
    input  ready
  );
  modport sink (
    input  valid, window_start_min, out_open, out_high, out_low, out_close,
           out_vwap, out_volume, out_trades,
    output ready
  );
endinterface

interface ohlcv_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ohlcv_pkg::CfgIdxW-1:0] index;
  logic [ohlcv_pkg::MinW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ohlcv_bar_aggregator_unit.sv
// OHLCV bar aggregator: folds fine bars into session-aligned coarser bars.
// Throughput: one item at a time; a fine bar is accepted, checked, multiplied (shift-add)
//   and accumulated; one that closes a window also runs the remainder and close steps, the
//   first bar after reset or flush also aligns to the session start; a flush closes any open
//   window. Emitting closes wait for output. VWAP: serial radix-2 divider, skipped when the
//   volume is zero or the average saturates. Reset: async active low; regs 570/960/5, idle.
`timescale 1ns / 1ps
`default_nettype none

module ohlcv_bar_aggregator_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ohlcv_bar_in_if.sink    bar_i,
  ohlcv_bar_out_if.source bar_o,
  ohlcv_cfg_if.sink       cfg_i
);

  localparam int unsigned PW = ohlcv_pkg::PriceW;
  localparam int unsigned VW = ohlcv_pkg::VolInW;
  localparam int unsigned SW = ohlcv_pkg::SumW;
  localparam int unsigned WW = ohlcv_pkg::WsW;
  localparam int unsigned MW = ohlcv_pkg::MinW;
  localparam int unsigned EW = ohlcv_pkg::EndW;
  localparam int unsigned CW = ohlcv_pkg::CntW;

  // ---------------- configuration registers ----------------
  logic [MW-1:0] sess_start_q, sess_end_q, bar_min_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_start_q <= ohlcv_pkg::SessStartRst;
      sess_end_q   <= ohlcv_pkg::SessEndRst;
      bar_min_q    <= ohlcv_pkg::BarMinRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        ohlcv_pkg::CfgSessStart: sess_start_q <= cfg_i.data;
        ohlcv_pkg::CfgSessEnd:   sess_end_q   <= cfg_i.data;
        ohlcv_pkg::CfgBarMin:    bar_min_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // zero bar length behaves as one minute
  logic [MW-1:0] bm_eff;
  assign bm_eff = (bar_min_q == '0) ? MW'(1) : bar_min_q;

  // ---------------- state ----------------
  ohlcv_pkg::agg_state_e state_q, state_d;

  // captured item
  logic          kind_q;
  logic [MW-1:0] time_q;
  logic [PW-1:0] open_q, high_q, low_q, close_q, avg_q;
  logic [VW-1:0] vol_q, trades_q;

  // window and accumulators
  logic          started_q, has_members_q;
  logic [MW-1:0] win_start_q;
  logic [EW-1:0] win_end_q;
  logic [PW-1:0] acc_open_q, acc_high_q, acc_low_q, acc_close_q;
  logic [WW-1:0] ws_q;
  logic [SW-1:0] acc_vol_q, acc_trd_q;

  // serial remainder unit (window alignment), shared counter, multiplier
  logic [MW-1:0]    rem_q, rdiv_q;
  logic             rem_start_q;  // remainder of session start vs. of elapsed time
  logic [CW-1:0]    cnt_q;
  logic [PW+VW-1:0] prod_q;

  // output register
  logic          out_valid_q, pend_q;
  logic [MW-1:0] o_start_q;
  logic [PW-1:0] o_open_q, o_high_q, o_low_q, o_close_q, o_vwap_q;
  logic [SW-1:0] o_vol_q, o_trd_q;

  // ---------------- datapath helpers ----------------
  logic          accept;
  logic          late;        // item time reached the window end
  logic          qualifies;   // open window would be emitted
  logic          out_free;
  logic          close_go, div_start;
  logic [MW:0]   rem_try, rem_nxt;
  logic          rem_ge;
  logic [EW-1:0] elapsed;
  logic [PW:0]   mul_sum;
  logic [WW:0]   ws_sum;
  logic [SW:0]   vol_sum, trd_sum;
  logic          div_done;
  logic [PW-1:0] div_quot;

  assign accept    = bar_i.valid && bar_i.ready;
  assign late      = {1'b0, time_q} >= win_end_q;
  assign qualifies = has_members_q && (win_end_q <= {1'b0, sess_end_q});
  assign out_free  = !out_valid_q && !pend_q;
  assign elapsed   = {1'b0, time_q} - win_end_q;

  // one restoring step: remainder of a minute count by the bar length
  assign rem_try = {rem_q, rdiv_q[MW-1]};
  assign rem_ge  = rem_try >= {1'b0, bm_eff};
  assign rem_nxt = rem_ge ? (rem_try - {1'b0, bm_eff}) : rem_try;

  // shift-add multiply, one volume bit a cycle
  assign mul_sum = {1'b0, prod_q[PW+VW-1:VW]} + {1'b0, (prod_q[0] ? avg_q : PW'(0))};

  assign ws_sum  = {1'b0, ws_q} + (WW+1)'(prod_q);
  assign vol_sum = {1'b0, acc_vol_q} + (SW+1)'(vol_q);
  assign trd_sum = {1'b0, acc_trd_q} + (SW+1)'(trades_q);

  // ---------------- control ----------------
  assign bar_i.ready = (state_q == ohlcv_pkg::ST_IDLE);

  always_comb begin
    state_d   = state_q;
    close_go  = 1'b0;
    div_start = 1'b0;
    case (state_q)
      ohlcv_pkg::ST_IDLE: begin
        if (bar_i.valid) begin
          if (bar_i.kind == ohlcv_pkg::KindFlush) begin
            state_d = started_q ? ohlcv_pkg::ST_CLOSE : ohlcv_pkg::ST_IDLE;
          end else begin
            state_d = started_q ? ohlcv_pkg::ST_CHECK : ohlcv_pkg::ST_REM;
          end
        end
      end
      ohlcv_pkg::ST_CHECK: begin
        state_d = late ? ohlcv_pkg::ST_REM : ohlcv_pkg::ST_MUL;
      end
      ohlcv_pkg::ST_REM: begin
        if (cnt_q == CW'(MW - 1)) begin
          state_d = rem_start_q ? ohlcv_pkg::ST_CHECK : ohlcv_pkg::ST_CLOSE;
        end
      end
      ohlcv_pkg::ST_CLOSE: begin
        // an emitting close waits for the output register and divider
        if (!qualifies || out_free) begin
          close_go  = 1'b1;
          div_start = qualifies;
          state_d   = (kind_q == ohlcv_pkg::KindFlush) ? ohlcv_pkg::ST_IDLE
                                                       : ohlcv_pkg::ST_MUL;
        end
      end
      ohlcv_pkg::ST_MUL: begin
        if (cnt_q == CW'(VW - 1)) begin
          state_d = ohlcv_pkg::ST_ACC;
        end
      end
      ohlcv_pkg::ST_ACC: begin
        state_d = ohlcv_pkg::ST_IDLE;
      end
      default: begin
        state_d = ohlcv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ohlcv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- item capture and serial units ----------------
  always_ff @(posedge clk_i) begin
    cnt_q <= (state_d != state_q) ? '0 : cnt_q + 1'b1;
    if (accept) begin
      kind_q   <= bar_i.kind;
      time_q   <= bar_i.bar_time_min;
      open_q   <= bar_i.open_price;
      high_q   <= bar_i.high_price;
      low_q    <= bar_i.low_price;
      close_q  <= bar_i.close_price;
      avg_q    <= bar_i.avg_price;
      vol_q    <= bar_i.bar_volume;
      trades_q <= bar_i.trade_count;
      prod_q   <= (PW+VW)'(bar_i.bar_volume);
      rem_q       <= '0;
      rdiv_q      <= sess_start_q;
      rem_start_q <= 1'b1;
    end
    case (state_q)
      ohlcv_pkg::ST_CHECK: begin
        rem_q       <= '0;
        rdiv_q      <= elapsed[MW-1:0];
        rem_start_q <= 1'b0;
      end
      ohlcv_pkg::ST_REM: begin
        rem_q  <= rem_nxt[MW-1:0];
        rdiv_q <= {rdiv_q[MW-2:0], 1'b0};
      end
      ohlcv_pkg::ST_MUL: begin
        prod_q <= {mul_sum, prod_q[VW-1:1]};
      end
      default: ;
    endcase
  end

  // ---------------- window and accumulators ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      win_start_q   <= '0;
      win_end_q     <= '0;
      has_members_q <= 1'b0;
      acc_open_q    <= '0;
      acc_high_q    <= '0;
      acc_low_q     <= '1;
      acc_close_q   <= '0;
      ws_q          <= '0;
      acc_vol_q     <= '0;
      acc_trd_q     <= '0;
    end else begin
      // first window: session start up to the next multiple of the bar length
      if (state_q == ohlcv_pkg::ST_REM && rem_start_q && cnt_q == CW'(MW - 1)) begin
        started_q     <= 1'b1;
        win_start_q   <= sess_start_q;
        win_end_q     <= {1'b0, sess_start_q} - EW'(rem_nxt[MW-1:0]) + {1'b0, bm_eff};
        has_members_q <= 1'b0;
        acc_open_q    <= '0;
        acc_high_q    <= '0;
        acc_low_q     <= '1;
        acc_close_q   <= '0;
        ws_q          <= '0;
        acc_vol_q     <= '0;
        acc_trd_q     <= '0;
      end
      if (close_go) begin
        has_members_q <= 1'b0;
        acc_open_q    <= '0;
        acc_high_q    <= '0;
        acc_low_q     <= '1;
        acc_close_q   <= '0;
        ws_q          <= '0;
        acc_vol_q     <= '0;
        acc_trd_q     <= '0;
        if (kind_q == ohlcv_pkg::KindFlush) begin
          started_q   <= 1'b0;
          win_start_q <= '0;
          win_end_q   <= '0;
        end else begin
          // skip ahead to the window holding the item time (empty ones vanish)
          win_start_q <= time_q - rem_q;
          win_end_q   <= {1'b0, time_q} - {1'b0, rem_q} + {1'b0, bm_eff};
        end
      end
      if (state_q == ohlcv_pkg::ST_ACC) begin
        has_members_q <= 1'b1;
        if (high_q > acc_high_q) acc_high_q <= high_q;
        if (low_q < acc_low_q)   acc_low_q  <= low_q;
        if (acc_open_q == '0)    acc_open_q <= open_q;
        acc_close_q <= close_q;
        ws_q        <= ws_sum[WW]  ? '1 : ws_sum[WW-1:0];
        acc_vol_q   <= vol_sum[SW] ? '1 : vol_sum[SW-1:0];
        acc_trd_q   <= trd_sum[SW] ? '1 : trd_sum[SW-1:0];
      end
    end
  end

  // ---------------- VWAP divider ----------------
  ohlcv_vwap_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ws_q),
    .divisor_i  (acc_vol_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      if (bar_o.valid && bar_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (div_start) begin
        pend_q <= 1'b1;
      end else if (div_done && pend_q) begin
        pend_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      o_start_q <= win_start_q;
      o_open_q  <= acc_open_q;
      o_high_q  <= acc_high_q;
      o_low_q   <= acc_low_q;
      o_close_q <= acc_close_q;
      o_vol_q   <= acc_vol_q;
      o_trd_q   <= acc_trd_q;
    end
    if (div_done) begin
      o_vwap_q <= div_quot;
    end
  end

  assign bar_o.valid            = out_valid_q;
  assign bar_o.window_start_min = o_start_q;
  assign bar_o.out_open         = o_open_q;
  assign bar_o.out_high         = o_high_q;
  assign bar_o.out_low          = o_low_q;
  assign bar_o.out_close        = o_close_q;
  assign bar_o.out_vwap         = o_vwap_q;
  assign bar_o.out_volume       = o_vol_q;
  assign bar_o.out_trades       = o_trd_q;

endmodule

`default_nettype wire

// File: rtl/core/ohlcv_vwap_div.sv
// Radix-2 restoring divider: weighted sum / volume, saturated to a price.
`timescale 1ns / 1ps
`default_nettype none

module ohlcv_vwap_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ohlcv_pkg::WsW-1:0]    dividend_i,
  input  wire logic [ohlcv_pkg::SumW-1:0]   divisor_i,
  output logic                              done_o,
  output logic [ohlcv_pkg::PriceW-1:0]      quot_o
);

  localparam int unsigned HiW = ohlcv_pkg::WsW - ohlcv_pkg::PriceW;
  localparam int unsigned PW  = ohlcv_pkg::PriceW;
  localparam int unsigned SW  = ohlcv_pkg::SumW;
  localparam int unsigned CW  = $clog2(PW);

  logic          busy_q, done_q;
  logic [SW-1:0] rem_q, dvs_q;
  logic [PW-1:0] dq_q;   // dividend low bits shift out, quotient bits shift in
  logic [CW-1:0] cnt_q;

  logic [HiW-1:0] hi;
  logic [SW:0]    trial;
  logic           ge;

  assign hi    = dividend_i[ohlcv_pkg::WsW-1:PW];
  assign trial = {rem_q, dq_q[PW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      dvs_q  <= '0;
      dq_q   <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (divisor_i == '0) begin
          dq_q   <= '0;
          done_q <= 1'b1;
        end else if (hi >= HiW'(divisor_i)) begin
          // quotient does not fit a price
          dq_q   <= '1;
          done_q <= 1'b1;
        end else begin
          rem_q  <= SW'(hi);
          dq_q   <= dividend_i[PW-1:0];
          dvs_q  <= divisor_i;
          cnt_q  <= '0;
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        rem_q <= ge ? SW'(trial - {1'b0, dvs_q}) : SW'(trial);
        dq_q  <= {dq_q[PW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(PW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

`default_nettype wire
